// ===== rtl/core/bpcr_pkg.sv =====
// types, address map constants and the alias combine function of the counter register block
package bpcr_pkg;

  localparam int NUM_COUNTERS_DEF = 4;
  localparam int COUNTER_BITS_DEF = 24;

  localparam int ADDR_W  = 14;
  localparam int DATA_W  = 32;
  localparam int OFS_W   = 12;
  localparam int PRIO_W  = 13;
  localparam int SEL_W   = 5;
  localparam int ALIAS_W = 2;

  localparam logic [OFS_W-1:0]  PRIO_OFS  = 12'h000;
  localparam logic [OFS_W-1:0]  ACK_OFS   = 12'h004;
  localparam logic [OFS_W-1:0]  CTR_BASE  = 12'h008;
  localparam logic [OFS_W-1:0]  SEL_BASE  = 12'h00c;
  localparam logic [OFS_W-1:0]  STRIDE    = 12'h008;
  localparam logic [PRIO_W-1:0] PRIO_MASK = 13'h1111;
  localparam logic [SEL_W-1:0]  SEL_OFF   = 5'h1f;
  localparam logic [DATA_W-1:0] ACK_VALUE = 32'h0000_0001;

  localparam logic [ALIAS_W-1:0] ALIAS_PLAIN = 2'd0;
  localparam logic [ALIAS_W-1:0] ALIAS_XOR   = 2'd1;
  localparam logic [ALIAS_W-1:0] ALIAS_SET   = 2'd2;
  localparam logic [ALIAS_W-1:0] ALIAS_CLR   = 2'd3;

  typedef struct packed {
    logic              mode;
    logic [ADDR_W-1:0] address;
    logic [DATA_W-1:0] write_data;
  } bpcr_req_t;

  typedef struct packed {
    logic [DATA_W-1:0] read_data;
    logic              unmapped;
  } bpcr_rsp_t;

  function automatic logic [DATA_W-1:0] combine(
    input logic [DATA_W-1:0]  old_value,
    input logic [DATA_W-1:0]  value,
    input logic [ALIAS_W-1:0] alias_code
  );
    logic [DATA_W-1:0] result;
    case (alias_code)
      ALIAS_XOR: result = old_value ^ value;
      ALIAS_SET: result = old_value | value;
      ALIAS_CLR: result = old_value & ~value;
      default:   result = value;
    endcase
    return result;
  endfunction

endpackage

// ===== rtl/core/bpcr_regs.sv =====
// address decode, register state and read-modify-write datapath
module bpcr_regs #(
  parameter int NUM_COUNTERS = bpcr_pkg::NUM_COUNTERS_DEF,
  parameter int COUNTER_BITS = bpcr_pkg::COUNTER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  bpcr_pkg::bpcr_req_t req,
  output bpcr_pkg::bpcr_rsp_t rsp
);
  import bpcr_pkg::*;

  logic [PRIO_W-1:0]       priority_bits;
  logic [COUNTER_BITS-1:0] counters  [NUM_COUNTERS];
  logic [SEL_W-1:0]        selectors [NUM_COUNTERS];

  logic [OFS_W-1:0]        ofs;
  logic [ALIAS_W-1:0]      alias_code;
  logic                    wr;
  logic [NUM_COUNTERS-1:0] ctr_hit;
  logic [NUM_COUNTERS-1:0] sel_hit;
  logic                    prio_hit;
  logic                    ack_hit;
  logic [COUNTER_BITS-1:0] ctr_next [NUM_COUNTERS];
  logic [SEL_W-1:0]        sel_next [NUM_COUNTERS];
  logic [PRIO_W-1:0]       priority_bits_next;
  logic [DATA_W-1:0]       rd;

  assign ofs        = req.address[OFS_W-1:0];
  assign alias_code = req.address[ADDR_W-1:OFS_W];
  assign wr         = req.mode;
  assign prio_hit   = (ofs == PRIO_OFS);
  assign ack_hit    = (ofs == ACK_OFS);

  always_comb begin
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      ctr_hit[i] = (ofs == OFS_W'(CTR_BASE + STRIDE * i));
      sel_hit[i] = (ofs == OFS_W'(SEL_BASE + STRIDE * i));
    end
  end

  always_comb begin
    rd = '0;
    priority_bits_next = PRIO_W'(combine(DATA_W'(priority_bits), req.write_data, alias_code))
                         & PRIO_MASK;
    for (int i = 0; i < NUM_COUNTERS; i++) begin
      if (wr) begin
        ctr_next[i] = COUNTER_BITS'(combine(DATA_W'(counters[i]), req.write_data, alias_code));
      end else if (selectors[i] != SEL_OFF && counters[i] != '1) begin
        ctr_next[i] = counters[i] + COUNTER_BITS'(1);
      end else begin
        ctr_next[i] = counters[i];
      end
      sel_next[i] = SEL_W'(combine(DATA_W'(selectors[i]), req.write_data, alias_code));
      if (!wr && ctr_hit[i]) rd = rd | DATA_W'(ctr_next[i]);
      if (!wr && sel_hit[i]) rd = rd | DATA_W'(selectors[i]);
    end
    if (!wr && prio_hit) rd = rd | DATA_W'(priority_bits);
    if (!wr && ack_hit)  rd = rd | ACK_VALUE;
  end

  assign rsp.read_data = rd;
  assign rsp.unmapped  = !(prio_hit || ack_hit || (|ctr_hit) || (|sel_hit));

  always_ff @(posedge clk) begin
    if (rst) begin
      priority_bits <= '0;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        counters[i]  <= '0;
        selectors[i] <= SEL_OFF;
      end
    end else if (fire) begin
      if (wr && prio_hit) priority_bits <= priority_bits_next;
      for (int i = 0; i < NUM_COUNTERS; i++) begin
        if (ctr_hit[i])       counters[i]  <= ctr_next[i];
        if (wr && sel_hit[i]) selectors[i] <= sel_next[i];
      end
    end
  end

endmodule

// ===== rtl/core/bus_perf_counter_regs_top.sv =====
// top level of the bus performance counter register block
//
// one request channel (req_valid, req_stall, req) carries bus accesses:
// mode 0 read, 1 write, a 14-bit address whose bits 13:12 pick the
// plain, xor, set or clear alias, and 32-bit write data
// one response channel (rsp_valid, rsp_stall, rsp) returns one transfer
// per request: read data (zero for writes) and an unmapped flag
// a request is taken into an input register, then decoded and applied to
// the register state at the same edge at which its response lands in an
// output register
// throughput is one access per cycle while rsp_stall is low, with the
// read-modify-write between the input and output registers
// while rsp_stall is high the response holds; the input register keeps
// one more request, after which req_stall rises
// synchronous reset empties both registers, clears priority and
// counters and sets every event selector to disabled
module bus_perf_counter_regs_top #(
  parameter int NUM_COUNTERS = bpcr_pkg::NUM_COUNTERS_DEF,
  parameter int COUNTER_BITS = bpcr_pkg::COUNTER_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  bpcr_pkg::bpcr_req_t req,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output bpcr_pkg::bpcr_rsp_t rsp
);
  import bpcr_pkg::*;

  logic      s1_valid;
  bpcr_req_t s1_req;
  logic      s1_valid_next;
  logic      s2_ready;
  logic      fire;
  logic      req_take;
  bpcr_rsp_t rsp_comb;

  assign s2_ready      = !rsp_valid || !rsp_stall;
  assign fire          = s1_valid && s2_ready;
  assign req_stall     = s1_valid && !s2_ready;
  assign req_take      = req_valid && !req_stall;
  assign s1_valid_next = req_take || (s1_valid && !fire);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      s1_valid <= s1_valid_next;
      if (s2_ready) rsp_valid <= fire;
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) s1_req <= req;
    if (fire)     rsp    <= rsp_comb;
  end

  bpcr_regs #(
    .NUM_COUNTERS(NUM_COUNTERS),
    .COUNTER_BITS(COUNTER_BITS)
  ) u_regs (
    .clk (clk),
    .rst (rst),
    .fire(fire),
    .req (s1_req),
    .rsp (rsp_comb)
  );

`ifndef SYNTHESIS
  a_stall_needs_held: assert property (@(posedge clk) disable iff (rst)
    req_stall |-> s1_valid)
    else $error("request stall without a held request");
  a_fire_gives_rsp: assert property (@(posedge clk) disable iff (rst)
    fire |=> rsp_valid)
    else $error("processed request gave no response");
  a_unmapped_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.unmapped) |-> (rsp.read_data == '0))
    else $error("unmapped response with nonzero read data");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!rsp_valid && !s1_valid))
    else $error("registers not empty after reset");
`endif

endmodule
